/* hw/rtl/eddc_pkg.sv */
// ============================================================================
// eddc_pkg
// Shared widths, codes and the control store of the epoch day converter.
// ============================================================================
package eddc_pkg;

    localparam int COUNT_W = 22;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int STAT_W  = 2;
    // The accumulator holds the date sum for the largest allowed MAX_YEAR
    // without wrapping, so the width check sees every overflow.
    localparam int ACC_W   = 25;
    localparam int STEP_W  = 4;

    localparam int EPOCH_YEAR = 1970;
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef logic [STEP_W-1:0] t_step;

    // Step addresses of the control program.
    localparam t_step S_DISPATCH  = 4'd0;
    localparam t_step S_YWALK     = 4'd1;
    localparam t_step S_YCHK      = 4'd2;
    localparam t_step S_MWALK     = 4'd3;
    localparam t_step S_D2C_OK    = 4'd4;
    localparam t_step S_D2C_RNG   = 4'd5;
    localparam t_step S_C2D_START = 4'd6;
    localparam t_step S_YSUM      = 4'd7;
    localparam t_step S_DCHK      = 4'd8;
    localparam t_step S_MSUM      = 4'd9;
    localparam t_step S_DAY       = 4'd10;
    localparam t_step S_WIDTH     = 4'd11;
    localparam t_step S_C2D_OK    = 4'd12;
    localparam t_step S_C2D_RNG   = 4'd13;
    localparam t_step S_C2D_BAD   = 4'd14;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACT_DATE,
        C_YSTOP,
        C_YOVER,
        C_MSTOP,
        C_YBAD,
        C_YREACH,
        C_DATE_BAD,
        C_MREACH,
        C_TOO_WIDE
    } t_cond;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_CLEAR,
        ACC_SUB_Y,
        ACC_SUB_M,
        ACC_ADD_Y,
        ACC_ADD_M,
        ACC_ADD_D
    } t_acc_op;

    typedef enum logic [1:0] {
        YR_HOLD,
        YR_INIT,
        YR_INC
    } t_yr_op;

    typedef enum logic [1:0] {
        MO_HOLD,
        MO_INIT,
        MO_INC
    } t_mo_op;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_D2C_OK,
        RES_D2C_RANGE,
        RES_C2D_OK,
        RES_C2D_BAD,
        RES_C2D_RANGE
    } t_res;

    // When gate is set, the datapath operations run only while the
    // condition is false; that turns one word into a loop body.
    typedef struct packed {
        t_cond   cond;
        t_step   jt;
        t_step   jf;
        logic    gate;
        t_acc_op acc;
        t_yr_op  yr;
        t_mo_op  mo;
        t_res    res;
    } t_uword;

    function automatic t_uword uw(t_cond c, t_step jt, t_step jf, logic g,
                                  t_acc_op a, t_yr_op y, t_mo_op m, t_res r);
        t_uword w;
        w.cond = c;
        w.jt   = jt;
        w.jf   = jf;
        w.gate = g;
        w.acc  = a;
        w.yr   = y;
        w.mo   = m;
        w.res  = r;
        return w;
    endfunction

    function automatic t_uword ucode(t_step pc);
        t_uword w;
        unique case (pc)
            S_DISPATCH:  w = uw(C_ACT_DATE, S_C2D_START, S_YWALK, 1'b0,
                                ACC_LOAD, YR_INIT, MO_INIT, RES_NONE);
            S_YWALK:     w = uw(C_YSTOP, S_YCHK, S_YWALK, 1'b1,
                                ACC_SUB_Y, YR_INC, MO_HOLD, RES_NONE);
            S_YCHK:      w = uw(C_YOVER, S_D2C_RNG, S_MWALK, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_NONE);
            S_MWALK:     w = uw(C_MSTOP, S_D2C_OK, S_MWALK, 1'b1,
                                ACC_SUB_M, YR_HOLD, MO_INC, RES_NONE);
            S_D2C_OK:    w = uw(C_ALWAYS, S_DISPATCH, S_DISPATCH, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_D2C_OK);
            S_D2C_RNG:   w = uw(C_ALWAYS, S_DISPATCH, S_DISPATCH, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_D2C_RANGE);
            S_C2D_START: w = uw(C_YBAD, S_C2D_RNG, S_YSUM, 1'b0,
                                ACC_CLEAR, YR_HOLD, MO_HOLD, RES_NONE);
            S_YSUM:      w = uw(C_YREACH, S_DCHK, S_YSUM, 1'b1,
                                ACC_ADD_Y, YR_INC, MO_HOLD, RES_NONE);
            S_DCHK:      w = uw(C_DATE_BAD, S_C2D_BAD, S_MSUM, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_NONE);
            S_MSUM:      w = uw(C_MREACH, S_DAY, S_MSUM, 1'b1,
                                ACC_ADD_M, YR_HOLD, MO_INC, RES_NONE);
            S_DAY:       w = uw(C_ALWAYS, S_WIDTH, S_WIDTH, 1'b0,
                                ACC_ADD_D, YR_HOLD, MO_HOLD, RES_NONE);
            S_WIDTH:     w = uw(C_TOO_WIDE, S_C2D_RNG, S_C2D_OK, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_NONE);
            S_C2D_OK:    w = uw(C_ALWAYS, S_DISPATCH, S_DISPATCH, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_C2D_OK);
            S_C2D_RNG:   w = uw(C_ALWAYS, S_DISPATCH, S_DISPATCH, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_C2D_RANGE);
            S_C2D_BAD:   w = uw(C_ALWAYS, S_DISPATCH, S_DISPATCH, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_C2D_BAD);
            default:     w = uw(C_ALWAYS, S_DISPATCH, S_DISPATCH, 1'b0,
                                ACC_HOLD, YR_HOLD, MO_HOLD, RES_C2D_BAD);
        endcase
        return w;
    endfunction

    // Month length; months outside 1..12 are never looked up for a result.
    function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/epoch_day_date_converter.sv */
// ============================================================================
// epoch_day_date_converter
// Converts between a day count since 1970-01-01 and a Gregorian date with a
// small microcoded sequencer that walks years and months one per cycle.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------------
//  input     i_in_valid / o_in_ready    i_action, i_days_in, i_year_in,
//                                       i_month_in, i_day_in
//  output    o_out_valid / i_out_ready  o_year_out, o_month_out, o_day_out,
//                                       o_count_out, o_status
//
//  A transaction walks one year per step and then one month per step,
//  plus up to five control steps for a day count or up to eight for a date,
//  and the sequencer then idles with o_in_ready high before it takes the
//  next request. The year loop of the sequencer dominates the time from
//  one accept to the next.
//  Reset clears the sequencer and the output valid; there is no clearing pass.
//  A new transaction is taken while a result waits at the output; the
//  sequencer stalls on its final step until the output register is free.
module epoch_day_date_converter #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [eddc_pkg::COUNT_W-1:0]    i_days_in,
    input  logic [eddc_pkg::YEAR_W-1:0]     i_year_in,
    input  logic [eddc_pkg::MONTH_W-1:0]    i_month_in,
    input  logic [eddc_pkg::DAY_W-1:0]      i_day_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [eddc_pkg::YEAR_W-1:0]     o_year_out,
    output logic [eddc_pkg::MONTH_W-1:0]    o_month_out,
    output logic [eddc_pkg::DAY_W-1:0]      o_day_out,
    output logic [eddc_pkg::COUNT_W-1:0]    o_count_out,
    output logic [eddc_pkg::STAT_W-1:0]     o_status
);
    import eddc_pkg::*;

    // The year register must hold MAX_YEAR + 1 after the last walk step.
    localparam int YW   = $clog2(MAX_YEAR + 2);
    localparam int CMPW = (YW > YEAR_W) ? YW : YEAR_W;
    localparam logic [CMPW-1:0] MAXY_C  = CMPW'(MAX_YEAR);
    localparam logic [CMPW-1:0] EPOCH_C = CMPW'(EPOCH_YEAR);

    // Sequencer control
    logic          r_busy, n_busy;
    t_step         r_pc, n_pc;
    t_uword        w_uw;
    logic          w_cond;
    logic          w_exec;
    logic          w_out_free;
    logic          w_finish;

    // Captured request
    logic                 r_action;
    logic [COUNT_W-1:0]   r_count_in;
    logic [YEAR_W-1:0]    r_year_in;
    logic [MONTH_W-1:0]   r_month_in;
    logic [DAY_W-1:0]     r_day_in;

    // Datapath
    logic [YW-1:0]        r_year, n_year;
    logic [1:0]           r_mod4, n_mod4;
    logic [6:0]           r_mod100, n_mod100;
    logic [8:0]           r_mod400, n_mod400;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [ACC_W-1:0]     r_acc, n_acc;

    logic                 w_leap;
    logic [8:0]           w_ylen;
    logic [DAY_W-1:0]     w_mlen;
    logic [DAY_W-1:0]     w_mlen_in;
    logic [CMPW-1:0]      w_year_ext;
    logic [CMPW-1:0]      w_year_in_ext;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [YEAR_W-1:0]    r_year_out, n_year_out;
    logic [MONTH_W-1:0]   r_month_out, n_month_out;
    logic [DAY_W-1:0]     r_day_out, n_day_out;
    logic [COUNT_W-1:0]   r_count_out, n_count_out;
    logic [STAT_W-1:0]    r_status, n_status;

    assign w_uw          = ucode(r_pc);
    assign w_leap        = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign w_ylen        = w_leap ? 9'd366 : 9'd365;
    assign w_mlen        = month_len(r_month, w_leap);
    assign w_mlen_in     = month_len(r_month_in, w_leap);
    assign w_year_ext    = CMPW'(r_year);
    assign w_year_in_ext = CMPW'(r_year_in);

    always_comb begin
        unique case (w_uw.cond)
            C_ALWAYS:   w_cond = 1'b1;
            C_ACT_DATE: w_cond = r_action;
            C_YSTOP:    w_cond = (w_year_ext > MAXY_C) || (r_acc < ACC_W'(w_ylen));
            C_YOVER:    w_cond = (w_year_ext > MAXY_C);
            C_MSTOP:    w_cond = (r_month == 4'd12) || (r_acc < ACC_W'(w_mlen));
            C_YBAD:     w_cond = (w_year_in_ext < EPOCH_C) || (w_year_in_ext > MAXY_C);
            C_YREACH:   w_cond = (w_year_ext == w_year_in_ext);
            // The year walk has finished here, so the leap flag is that of year_in.
            C_DATE_BAD: w_cond = (r_month_in == 4'd0) || (r_month_in > 4'd12)
                                 || (r_day_in == 5'd0) || (r_day_in > w_mlen_in);
            C_MREACH:   w_cond = (r_month == r_month_in);
            C_TOO_WIDE: w_cond = (r_acc[ACC_W-1:COUNT_W] != '0);
            default:    w_cond = 1'b1;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = r_busy && (w_uw.res != RES_NONE) && w_out_free;
    assign w_exec     = r_busy && !(w_uw.gate && w_cond);
    assign o_in_ready = !r_busy;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_in_valid) begin
                n_busy = 1'b1;
                n_pc   = S_DISPATCH;
            end
        end else if (w_uw.res != RES_NONE) begin
            if (w_out_free) begin
                n_busy = 1'b0;
            end
        end else begin
            n_pc = w_cond ? w_uw.jt : w_uw.jf;
        end
    end

    always_comb begin
        n_year   = r_year;
        n_mod4   = r_mod4;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        n_month  = r_month;
        n_acc    = r_acc;
        if (w_exec) begin
            unique case (w_uw.yr)
                YR_INIT: begin
                    n_year   = YW'(EPOCH_YEAR);
                    n_mod4   = EPOCH_MOD4;
                    n_mod100 = EPOCH_MOD100;
                    n_mod400 = EPOCH_MOD400;
                end
                YR_INC: begin
                    n_year   = r_year + YW'(1);
                    n_mod4   = r_mod4 + 2'd1;
                    n_mod100 = (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
                    n_mod400 = (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
                end
                default: begin
                end
            endcase
            unique case (w_uw.mo)
                MO_INIT: n_month = 4'd1;
                MO_INC:  n_month = r_month + 4'd1;
                default: begin
                end
            endcase
            unique case (w_uw.acc)
                ACC_LOAD:  n_acc = ACC_W'(r_count_in);
                ACC_CLEAR: n_acc = '0;
                ACC_SUB_Y: n_acc = r_acc - ACC_W'(w_ylen);
                ACC_SUB_M: n_acc = r_acc - ACC_W'(w_mlen);
                ACC_ADD_Y: n_acc = r_acc + ACC_W'(w_ylen);
                ACC_ADD_M: n_acc = r_acc + ACC_W'(w_mlen);
                ACC_ADD_D: n_acc = r_acc + ACC_W'(r_day_in) - ACC_W'(1);
                default:   n_acc = r_acc;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_year_out  = r_year_out;
        n_month_out = r_month_out;
        n_day_out   = r_day_out;
        n_count_out = r_count_out;
        n_status    = r_status;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_finish) begin
            n_out_valid = 1'b1;
            n_year_out  = r_year_in;
            n_month_out = r_month_in;
            n_day_out   = r_day_in;
            n_count_out = '0;
            unique case (w_uw.res)
                RES_D2C_OK: begin
                    n_year_out  = w_year_ext[YEAR_W-1:0];
                    n_month_out = r_month;
                    n_day_out   = r_acc[DAY_W-1:0] + 5'd1;
                    n_count_out = r_count_in;
                    n_status    = ST_OK;
                end
                RES_D2C_RANGE: begin
                    n_year_out  = '0;
                    n_month_out = '0;
                    n_day_out   = '0;
                    n_count_out = r_count_in;
                    n_status    = ST_RANGE;
                end
                RES_C2D_OK: begin
                    n_count_out = r_acc[COUNT_W-1:0];
                    n_status    = ST_OK;
                end
                RES_C2D_BAD: begin
                    n_status    = ST_BAD;
                end
                default: begin
                    n_status    = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= S_DISPATCH;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action   <= i_action;
            r_count_in <= i_days_in;
            r_year_in  <= i_year_in;
            r_month_in <= i_month_in;
            r_day_in   <= i_day_in;
        end
        r_year      <= n_year;
        r_mod4      <= n_mod4;
        r_mod100    <= n_mod100;
        r_mod400    <= n_mod400;
        r_month     <= n_month;
        r_acc       <= n_acc;
        r_year_out  <= n_year_out;
        r_month_out <= n_month_out;
        r_day_out   <= n_day_out;
        r_count_out <= n_count_out;
        r_status    <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_year_out  = r_year_out;
    assign o_month_out = r_month_out;
    assign o_day_out   = r_day_out;
    assign o_count_out = r_count_out;
    assign o_status    = r_status;

endmodule

/* verif/epoch_day_date_converter_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// epoch_day_date_converter_tb
// Self-checking bench for the epoch day converter. Directed edge cases come
// first, then weighted random conversions in both directions. The expected
// results come from a behavioral calendar model in the bench and are compared
// in order against every result transaction.
// ============================================================================
module epoch_day_date_converter_tb;
    import eddc_pkg::*;

    localparam int unsigned TB_MAX_YEAR = 9999;
    localparam int unsigned LAST_COUNT  = 2932896;    // 9999-12-31
    localparam int unsigned COUNT_LIMIT = 22'h3FFFFF;
    localparam int unsigned DRAIN_WAIT  = 8100;        // longest walk plus margin

    typedef enum logic {
        TO_DATE  = 1'b0,
        TO_COUNT = 1'b1
    } t_conv_dir;

    typedef struct packed {
        t_conv_dir          dir;
        logic [COUNT_W-1:0] days;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_conv_req;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } t_conv_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic               i_action    = 1'b0;
    logic [COUNT_W-1:0] i_days_in   = '0;
    logic [YEAR_W-1:0]  i_year_in   = '0;
    logic [MONTH_W-1:0] i_month_in  = '0;
    logic [DAY_W-1:0]   i_day_in    = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [YEAR_W-1:0]  o_year_out;
    logic [MONTH_W-1:0] o_month_out;
    logic [DAY_W-1:0]   o_day_out;
    logic [COUNT_W-1:0] o_count_out;
    logic [STAT_W-1:0]  o_status;

    t_conv_result pending_conversions[$];
    int unsigned  mismatch_count = 0;
    int unsigned  burst_left     = 0;
    logic [9:0]   ready_phase    = '0;

    epoch_day_date_converter #(
        .MAX_YEAR(TB_MAX_YEAR)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_days_in(i_days_in),
        .i_year_in(i_year_in),
        .i_month_in(i_month_in),
        .i_day_in(i_day_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_year_out(o_year_out),
        .o_month_out(o_month_out),
        .o_day_out(o_day_out),
        .o_count_out(o_count_out),
        .o_status(o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------
    function automatic bit year_is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned year_days(int unsigned y);
        return year_is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_days(int unsigned m, bit leap);
        case (m)
            2:              return leap ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    function automatic t_conv_result predict_conversion(t_conv_req req);
        t_conv_result r;
        int unsigned  remaining;
        int unsigned  yr;
        int unsigned  mo;
        longint       total;
        bit           leap;
        r = '0;
        if (req.dir == TO_DATE) begin
            r.count   = req.days;
            remaining = req.days;
            yr        = EPOCH_YEAR;
            while (yr <= TB_MAX_YEAR && remaining >= year_days(yr)) begin
                remaining -= year_days(yr);
                yr++;
            end
            if (yr > TB_MAX_YEAR) begin
                r.status = ST_RANGE;
            end else begin
                leap = year_is_leap(yr);
                mo   = 1;
                while (mo < 12 && remaining >= month_days(mo, leap)) begin
                    remaining -= month_days(mo, leap);
                    mo++;
                end
                r.year  = YEAR_W'(yr);
                r.month = MONTH_W'(mo);
                r.day   = DAY_W'(remaining + 1);
            end
        end else begin
            r.year  = req.year;
            r.month = req.month;
            r.day   = req.day;
            if (req.year < EPOCH_YEAR || req.year > TB_MAX_YEAR) begin
                r.status = ST_RANGE;
            end else if (req.month < 1 || req.month > 12 || req.day < 1 ||
                         req.day > month_days(req.month, year_is_leap(req.year))) begin
                r.status = ST_BAD;
            end else begin
                leap  = year_is_leap(req.year);
                total = 0;
                for (yr = EPOCH_YEAR; yr < req.year; yr++)
                    total += year_days(yr);
                for (mo = 1; mo < req.month; mo++)
                    total += month_days(mo, leap);
                total += req.day - 1;
                if (total > COUNT_LIMIT)
                    r.status = ST_RANGE;
                else
                    r.count = COUNT_W'(total);
            end
        end
        return r;
    endfunction

    // Unused fields of a request carry random values to toggle their bits.
    function automatic t_conv_req count_req(int unsigned count);
        t_conv_req req;
        req.dir   = TO_DATE;
        req.days  = COUNT_W'(count);
        req.year  = YEAR_W'($urandom);
        req.month = MONTH_W'($urandom);
        req.day   = DAY_W'($urandom);
        return req;
    endfunction

    function automatic t_conv_req date_req(int unsigned y, int unsigned m, int unsigned d);
        t_conv_req req;
        req.dir   = TO_COUNT;
        req.days  = COUNT_W'($urandom);
        req.year  = YEAR_W'(y);
        req.month = MONTH_W'(m);
        req.day   = DAY_W'(d);
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic issue_conversion(input t_conv_req req);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action   <= req.dir;
        i_days_in  <= req.days;
        i_year_in  <= req.year;
        i_month_in <= req.month;
        i_day_in   <= req.day;
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        pending_conversions.push_back(predict_conversion(req));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_conversions.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern changes with the top bits of a phase counter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_phase[9:8])
            2'd0:    i_out_ready <= 1'b1;
            2'd1:    i_out_ready <= 1'($urandom);
            2'd2:    i_out_ready <= (ready_phase[5:0] == 6'd0);
            default: i_out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_conv_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_conversions.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got status %0d",
                         $time, o_status);
            end else begin
                want = pending_conversions.pop_front();
                check_field("year",   want.year,   o_year_out);
                check_field("month",  want.month,  o_month_out);
                check_field("day",    want.day,    o_day_out);
                check_field("count",  want.count,  o_count_out);
                check_field("status", want.status, o_status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_epoch_and_limits();
        issue_conversion(count_req(0));
        issue_conversion(count_req(364));
        issue_conversion(count_req(365));
        issue_conversion(count_req(LAST_COUNT));
        issue_conversion(count_req(LAST_COUNT + 1));
        issue_conversion(count_req(COUNT_LIMIT));
        issue_conversion(date_req(1970, 1, 1));
        issue_conversion(date_req(9999, 12, 31));
        issue_conversion(date_req(10000, 1, 1));
        issue_conversion(date_req(16383, 15, 31));
        issue_conversion(date_req(0, 0, 0));
        // A year out of range wins over a bad month and day.
        issue_conversion(date_req(1969, 13, 0));
    endtask

    task automatic test_leap_years();
        issue_conversion(count_req(789));      // 1972-02-29
        issue_conversion(count_req(11016));    // 2000-02-29
        issue_conversion(count_req(47541));    // 2100-03-01
        issue_conversion(date_req(2000, 2, 29));
        issue_conversion(date_req(2100, 2, 29));
        issue_conversion(date_req(2100, 2, 28));
    endtask

    task automatic test_invalid_fields();
        issue_conversion(date_req(2023, 0, 10));
        issue_conversion(date_req(2023, 13, 1));
        issue_conversion(date_req(2023, 4, 31));
        issue_conversion(date_req(2023, 6, 0));
        issue_conversion(date_req(2023, 12, 31));
    endtask

    task automatic test_drain_pause();
        repeat (3) issue_conversion(count_req($urandom_range(0, 20000)));
        drain_results();
        repeat (3) issue_conversion(date_req($urandom_range(1970, 2030), 6, 15));
    endtask

    // Most requests stay within two centuries of the epoch to keep walks short.
    task automatic test_random_conversions(input int unsigned n_items);
        int unsigned pick;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 45) begin
                if (pick < 75)
                    issue_conversion(count_req($urandom_range(0, 73049)));
                else if (pick < 90)
                    issue_conversion(count_req($urandom_range(0, LAST_COUNT)));
                else
                    issue_conversion(count_req($urandom_range(LAST_COUNT + 1, COUNT_LIMIT)));
            end else begin
                if (pick < 70)
                    yr = EPOCH_YEAR + $urandom_range(0, 200);
                else if (pick < 85)
                    yr = $urandom_range(EPOCH_YEAR, TB_MAX_YEAR);
                else if (pick < 93)
                    yr = $urandom_range(0, EPOCH_YEAR - 1);
                else
                    yr = $urandom_range(TB_MAX_YEAR + 1, 16383);
                if ($urandom_range(0, 99) < 85) begin
                    mo = $urandom_range(1, 12);
                end else begin
                    mo = $urandom_range(0, 3);
                    mo = (mo == 0) ? 0 : 12 + mo;
                end
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    dy = $urandom_range(1, month_days(mo, year_is_leap(yr)));
                else if (pick < 90)
                    dy = 0;
                else
                    dy = $urandom_range(0, 31);
                issue_conversion(date_req(yr, mo, dy));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_epoch_and_limits();
        test_leap_years();
        test_invalid_fields();
        test_drain_pause();
        test_random_conversions(70);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
